FILE: design/scd_pkg.sv
package scd_pkg;

    // Field widths of one input item and one result item.
    localparam int SAMPLE_W   = 16;
    localparam int TIME_W     = 32;
    localparam int BASE_W     = 32;
    localparam int S_DATA_W   = 80;
    localparam int M_DATA_W   = 24;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Serial divider width and its step counter width.
    localparam int DIV_W      = 20;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

    // Fixed constants of the detection scheme.
    localparam logic [TIME_W-1:0] SLOW_INTERVAL = 32'd28;
    localparam logic [DIV_W-1:0]  PEN_DIVISOR   = 20'd10;
    localparam logic [1:0]        FAULT_FULL    = 2'd3;
    localparam logic [1:0]        SMOKE_FULL    = 2'd2;
    localparam logic [1:0]        PART_FULL     = 2'd3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RED_THRESH     = 3'd0,
        REG_BLUE_THRESH    = 3'd1,
        REG_LEAK_THRESH    = 3'd2,
        REG_CHAMBER_THRESH = 3'd3,
        REG_PART_RATIO     = 3'd4
    } cfg_index_t;

    // Sequencer states for one item.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAP,
        ST_STEP,
        ST_BASE,
        ST_DELTA,
        ST_START,
        ST_DIV,
        ST_PEN,
        ST_EVAL,
        ST_OUT
    } scd_state_t;

    // Integer third of an 8-bit value by reciprocal multiply (exact below 256).
    function automatic logic [7:0] div3(input logic [7:0] x);
        logic [15:0] p;
        p = 16'(x) * 16'd171;
        return {1'b0, p[15:9]};
    endfunction

endpackage

FILE: design/scd_serial_div.sv
module scd_serial_div
    import scd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             busy,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    logic [DIV_W:0]       rem_shift;
    logic [DIV_W:0]       diff;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign rem_shift = {rem_reg, quo_reg[DIV_W-1]};
    assign diff      = rem_shift - {1'b0, den_reg};

    // Step counter and busy flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder and quotient shift registers, one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            if (!diff[DIV_W]) begin
                rem_reg <= diff[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: design/scd_history.sv
module scd_history
    import scd_pkg::*;
#(
    parameter int DEPTH = 6
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                insert,
    input  logic [SAMPLE_W-1:0] din,
    output logic [SAMPLE_W-1:0] tap
);

    logic [SAMPLE_W-1:0] hist_reg [DEPTH];

    // Shift line, oldest entry at index zero; a new sample enters at the top.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                hist_reg[i] <= '0;
            end
        end else if (insert) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                hist_reg[i] <= hist_reg[i+1];
            end
            hist_reg[DEPTH-1] <= din;
        end
    end

    // The rate penalty looks at the entry just below the newest one.
    assign tap = hist_reg[DEPTH-2];

endmodule

FILE: design/smoke_chamber_detector_top.sv
// Smoke chamber detector. Each input item carries one chamber sample (forward
// red, forward blue, background and a seconds timestamp) and yields exactly one
// result item with the sticky smoke and big-particle alarms, the light-leak and
// chamber faults and the integer part of the red baseline. Items are processed
// one at a time: the next item is accepted only once the sequencer is back in
// idle, and most of the sequence is spent in the 20-step bit-serial dividers
// (rate penalty and red/blue delta quotient run side by side). The result sits
// in an output register, so the next item is accepted while an earlier result
// still waits. Configuration writes are accepted at any time and must only be
// issued while the block is idle.
module smoke_chamber_detector_top
    import scd_pkg::*;
#(
    parameter int SLOW_HISTORY_DEPTH = 6
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // front_red, front_blue, background, time_seconds (from bit 0 up)
    input  logic [S_DATA_W-1:0]   s_tdata,

    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // smoke_alarm, big_particle_alarm, light_leak_fault, chamber_fault,
    // red_baseline, zero fill (from bit 0 up)
    output logic [M_DATA_W-1:0]   m_tdata,

    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    scd_state_t state_reg, state_next;

    // Configuration registers.
    logic [7:0]          red_thresh_reg;
    logic [7:0]          red_filt_reg;
    logic [7:0]          blue_thresh_reg;
    logic [15:0]         leak_thresh_reg;
    logic [15:0]         chamber_thresh_reg;
    logic [7:0]          ratio_reg;

    // Current item.
    logic [SAMPLE_W-1:0] red_reg, blue_reg, bg_reg;
    logic [TIME_W-1:0]   now_reg;

    // Persistent detector state.
    logic [TIME_W-1:0]   last_time_reg;
    logic [BASE_W-1:0]   red_base_reg, blue_base_reg;
    logic [1:0]          leak_count_reg, chamber_count_reg;
    logic [1:0]          smoke_count_reg, part_count_reg;
    logic                smoke_latched_reg, part_latched_reg;

    // Per-item working registers.
    logic [BASE_W:0]     gap_r_reg, gap_b_reg;
    logic                upd_r_reg, upd_b_reg;
    logic                zero_r_reg, zero_b_reg;
    logic [23:0]         step_r_reg, step_b_reg;
    logic                red_gt_h_reg;
    logic [DIV_W-1:0]    pen_num_reg;
    logic [SAMPLE_W-1:0] mag_r_reg, mag_b_reg;
    logic                q_neg_reg, blue_zero_reg;
    logic [SAMPLE_W-1:0] pen_reg;

    // Output register.
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Control.
    logic                in_accept;
    logic                div_start;
    logic                out_load;
    logic                slow_due;
    logic                hist_insert;
    logic [SAMPLE_W-1:0] hist_tap;

    // Datapath combinational terms.
    logic [BASE_W:0]     gap_r, gap_b;
    logic [SAMPLE_W-1:0] h_diff;
    logic [DIV_W-1:0]    pen_num;
    logic [39:0]         scaled_r, scaled_b;
    logic [BASE_W-1:0]   red_scaled, blue_scaled;
    logic                pos_r, pos_b;
    logic [BASE_W-1:0]   up_r, dn_r, up_b, dn_b;
    logic                leak_hit, chamber_hit;
    logic [1:0]          leak_count_next, chamber_count_next;
    logic [BASE_W:0]     pen_gap;
    logic                smoke_hit, part_hit, fault_free;
    logic [1:0]          smoke_count_next, part_count_next;
    logic                pen_busy, rat_busy;
    logic [DIV_W-1:0]    pen_q, rat_q;

    assign cfg_ready = 1'b1;
    assign in_accept = s_tvalid && s_tready;

    // Configuration register writes; the red filter threshold is kept as a third.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_thresh_reg     <= 8'd20;
            red_filt_reg       <= 8'd6;
            blue_thresh_reg    <= 8'd10;
            leak_thresh_reg    <= 16'd200;
            chamber_thresh_reg <= 16'd200;
            ratio_reg          <= 8'd3;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_RED_THRESH: begin
                    red_thresh_reg <= cfg_data[7:0];
                    red_filt_reg   <= div3(cfg_data[7:0]);
                end
                REG_BLUE_THRESH:    blue_thresh_reg    <= cfg_data[7:0];
                REG_LEAK_THRESH:    leak_thresh_reg    <= cfg_data;
                REG_CHAMBER_THRESH: chamber_thresh_reg <= cfg_data;
                REG_PART_RATIO:     ratio_reg          <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and sequencer outputs.
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_GAP;
                end
            end
            ST_GAP:   state_next = ST_STEP;
            ST_STEP:  state_next = ST_BASE;
            ST_BASE:  state_next = ST_DELTA;
            ST_DELTA: state_next = ST_START;
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (!pen_busy && !rat_busy) begin
                    state_next = ST_PEN;
                end
            end
            ST_PEN:   state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_OUT;
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Capture the item.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            red_reg  <= s_tdata[15:0];
            blue_reg <= s_tdata[31:16];
            bg_reg   <= s_tdata[47:32];
            now_reg  <= s_tdata[79:48];
        end
    end

    // Slow history: insert when at least the interval has gone by (wrapping).
    assign slow_due    = (now_reg - last_time_reg) >= SLOW_INTERVAL;
    assign hist_insert = (state_reg == ST_GAP) && slow_due;

    scd_history #(
        .DEPTH (SLOW_HISTORY_DEPTH)
    ) u_history (
        .aclk    (aclk),
        .aresetn (aresetn),
        .insert  (hist_insert),
        .din     (red_reg),
        .tap     (hist_tap)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
        end else if (hist_insert) begin
            last_time_reg <= now_reg;
        end
    end

    // Signed gap from each baseline to its sample, in Q16.16.
    assign gap_r = {1'b0, red_reg, 16'h0} - {1'b0, red_base_reg};
    assign gap_b = {1'b0, blue_reg, 16'h0} - {1'b0, blue_base_reg};

    always_ff @(posedge aclk) begin
        if (state_reg == ST_GAP) begin
            gap_r_reg  <= gap_r;
            gap_b_reg  <= gap_b;
            upd_r_reg  <= $signed(gap_r) < $signed({9'h0, red_filt_reg, 16'h0});
            upd_b_reg  <= $signed(gap_b) < $signed({9'h0, blue_thresh_reg, 16'h0});
            zero_r_reg <= (red_base_reg == '0);
            zero_b_reg <= (blue_base_reg == '0);
        end
    end

    // Baseline step: floor(gap * 66 / 65536), with 66 = 64 + 2.
    assign scaled_r = {gap_r_reg[BASE_W], gap_r_reg, 6'h0} +
                      {{6{gap_r_reg[BASE_W]}}, gap_r_reg, 1'b0};
    assign scaled_b = {gap_b_reg[BASE_W], gap_b_reg, 6'h0} +
                      {{6{gap_b_reg[BASE_W]}}, gap_b_reg, 1'b0};

    // Penalty numerator: (red - h) * 9, divided by ten later (same as * 90 / 100).
    assign h_diff  = red_reg - hist_tap;
    assign pen_num = {1'b0, h_diff, 3'h0} + {4'h0, h_diff};

    always_ff @(posedge aclk) begin
        if (state_reg == ST_STEP) begin
            step_r_reg   <= scaled_r[39:16];
            step_b_reg   <= scaled_b[39:16];
            red_gt_h_reg <= red_reg > hist_tap;
            pen_num_reg  <= pen_num;
        end
    end

    // Baseline update: load on first use, otherwise follow while below the filter.
    assign red_scaled  = red_base_reg + {{8{step_r_reg[23]}}, step_r_reg};
    assign blue_scaled = blue_base_reg + {{8{step_b_reg[23]}}, step_b_reg};

    // Red and blue deltas, truncated toward zero, as sign and magnitude.
    assign pos_r = {red_reg, 16'h0} >= red_base_reg;
    assign pos_b = {blue_reg, 16'h0} >= blue_base_reg;
    assign up_r  = {red_reg, 16'h0} - red_base_reg;
    assign dn_r  = red_base_reg - {red_reg, 16'h0};
    assign up_b  = {blue_reg, 16'h0} - blue_base_reg;
    assign dn_b  = blue_base_reg - {blue_reg, 16'h0};

    // Fault hits: background over the leak level, updated red baseline over the chamber level.
    assign leak_hit    = bg_reg > leak_thresh_reg;
    assign chamber_hit = red_base_reg > {chamber_thresh_reg, 16'h0};
    assign leak_count_next = !leak_hit ? 2'd0 :
                             (leak_count_reg == FAULT_FULL) ? FAULT_FULL :
                             leak_count_reg + 2'd1;
    assign chamber_count_next = !chamber_hit ? 2'd0 :
                                (chamber_count_reg == FAULT_FULL) ? FAULT_FULL :
                                chamber_count_reg + 2'd1;

    // Penalized red against the baseline decides the smoke hit.
    assign pen_gap    = {1'b0, pen_reg, 16'h0} - {1'b0, red_base_reg};
    assign smoke_hit  = !pen_gap[BASE_W] && (pen_gap[31:16] > {8'h0, red_thresh_reg});
    assign part_hit   = !q_neg_reg && (rat_q > {12'h0, ratio_reg});
    assign fault_free = (leak_count_reg != FAULT_FULL) && (chamber_count_reg != FAULT_FULL);

    assign smoke_count_next = smoke_hit ?
                              ((smoke_count_reg == SMOKE_FULL) ? SMOKE_FULL :
                               smoke_count_reg + 2'd1) :
                              ((smoke_count_reg == 2'd0) ? 2'd0 : smoke_count_reg - 2'd1);
    assign part_count_next = part_hit ?
                             ((part_count_reg == PART_FULL) ? PART_FULL :
                              part_count_reg + 2'd1) :
                             ((part_count_reg == 2'd0) ? 2'd0 : part_count_reg - 2'd1);

    // Detector state updates, one step of the item at a time.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_base_reg      <= '0;
            blue_base_reg     <= '0;
            leak_count_reg    <= '0;
            chamber_count_reg <= '0;
            smoke_count_reg   <= '0;
            part_count_reg    <= '0;
            smoke_latched_reg <= 1'b0;
            part_latched_reg  <= 1'b0;
        end else begin
            if (state_reg == ST_BASE) begin
                if (zero_r_reg) begin
                    red_base_reg <= {red_reg, 16'h0};
                end else if (upd_r_reg) begin
                    red_base_reg <= red_scaled;
                end
                if (zero_b_reg) begin
                    blue_base_reg <= {blue_reg, 16'h0};
                end else if (upd_b_reg) begin
                    blue_base_reg <= blue_scaled;
                end
            end
            if (state_reg == ST_DELTA) begin
                leak_count_reg    <= leak_count_next;
                chamber_count_reg <= chamber_count_next;
            end
            if ((state_reg == ST_EVAL) && fault_free) begin
                smoke_count_reg <= smoke_count_next;
                if (smoke_count_next == SMOKE_FULL) begin
                    smoke_latched_reg <= 1'b1;
                end
                if (!blue_zero_reg) begin
                    part_count_reg <= part_count_next;
                    if (part_count_next == PART_FULL) begin
                        part_latched_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Delta magnitudes and the quotient sign for the particle test.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DELTA) begin
            mag_r_reg     <= pos_r ? up_r[31:16] : dn_r[31:16];
            mag_b_reg     <= pos_b ? up_b[31:16] : dn_b[31:16];
            blue_zero_reg <= pos_b ? (up_b[31:16] == '0) : (dn_b[31:16] == '0);
            q_neg_reg     <= pos_r ^ pos_b;
        end
    end

    // Rate penalty and particle quotient run side by side in serial dividers.
    scd_serial_div u_pen_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (pen_num_reg),
        .divisor  (PEN_DIVISOR),
        .busy     (pen_busy),
        .quotient (pen_q)
    );

    scd_serial_div u_rat_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({4'h0, mag_r_reg}),
        .divisor  ({4'h0, mag_b_reg}),
        .busy     (rat_busy),
        .quotient (rat_q)
    );

    // Penalized red sample.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_PEN) begin
            pen_reg <= red_gt_h_reg ? red_reg - pen_q[15:0] : red_reg;
        end
    end

    // Output register: holds the result until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {4'h0, red_base_reg[31:16],
                            chamber_count_reg == FAULT_FULL,
                            leak_count_reg == FAULT_FULL,
                            part_latched_reg, smoke_latched_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: tb/smoke_chamber_detector_top_test.sv
`timescale 1ns / 100ps

module smoke_chamber_detector_top_test;
    import scd_pkg::*;

    // Detector constants as the scheme defines them.
    localparam int          HIST_DEPTH       = 6;
    localparam logic [31:0] SLOW_INTERVAL_S  = 32'd28;
    localparam longint      BASE_STEP        = 66;
    localparam int unsigned PEN_NUM          = 90;
    localparam int unsigned PEN_DEN          = 100;
    localparam int unsigned FILTER_DIV       = 3;
    localparam logic [1:0]  FAULT_MAX        = 2'd3;
    localparam logic [1:0]  SMOKE_MAX        = 2'd2;
    localparam logic [1:0]  PARTICLE_MAX     = 2'd3;
    localparam int          FIRST_UNUSED_REG = int'(REG_PART_RATIO) + 1;

    // Run shape.
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int DRAIN_CYCLES   = 40;

    // One input item: front_red in the lowest bits, time_seconds in the highest.
    typedef struct packed {
        logic [31:0] secs;
        logic [15:0] background;
        logic [15:0] blue;
        logic [15:0] red;
    } chamber_sample_t;

    // One result item: smoke_alarm in bit 0, zero fill on top.
    typedef struct packed {
        logic [3:0]  fill;
        logic [15:0] red_baseline;
        logic        chamber_fault;
        logic        leak_fault;
        logic        particle_alarm;
        logic        smoke_alarm;
    } detector_result_t;

    // Tracks the detector state and the results still owed by the block.
    class detector_scoreboard;
        logic [7:0]  red_thresh, blue_thresh, ratio;
        logic [15:0] leak_thresh, chamber_thresh;
        logic [31:0] red_base, blue_base, last_slow;
        logic [15:0] slow_hist [HIST_DEPTH];
        logic [1:0]  leak_cnt, chamber_cnt, smoke_cnt, particle_cnt;
        logic        smoke_latch, particle_latch;
        detector_result_t expected_q[$];
        int errors, fault_items, flat_blue_items;

        function new();
            red_thresh = 8'd20;
            blue_thresh = 8'd10;
            leak_thresh = 16'd200;
            chamber_thresh = 16'd200;
            ratio = 8'd3;
            red_base = '0;
            blue_base = '0;
            last_slow = '0;
            foreach (slow_hist[i]) slow_hist[i] = '0;
            leak_cnt = '0;
            chamber_cnt = '0;
            smoke_cnt = '0;
            particle_cnt = '0;
            smoke_latch = 1'b0;
            particle_latch = 1'b0;
            errors = 0;
            fault_items = 0;
            flat_blue_items = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_RED_THRESH:     red_thresh = val[7:0];
                REG_BLUE_THRESH:    blue_thresh = val[7:0];
                REG_LEAK_THRESH:    leak_thresh = val;
                REG_CHAMBER_THRESH: chamber_thresh = val;
                REG_PART_RATIO:     ratio = val[7:0];
                default: ;
            endcase
        endfunction

        // Signed Q16.16 distance from a baseline up to an integer level.
        function longint q16_gap(int unsigned level, logic [31:0] base);
            return longint'(level) * 65536 - longint'(base);
        endfunction

        function longint trunc_q16(longint v);
            return (v >= 0) ? (v >>> 16) : -((-v) >>> 16);
        endfunction

        // Load on first use, else creep toward the sample unless it rises too far.
        function logic [31:0] move_base(logic [31:0] base, int unsigned level,
                                        int unsigned thr);
            longint gap;
            if (base == 0)
                return {level[15:0], 16'h0};
            gap = q16_gap(level, base);
            if (gap < longint'(thr) * 65536)
                base = 32'(longint'(base) + ((gap * BASE_STEP) >>> 16));
            return base;
        endfunction

        function logic [1:0] bump_fault(logic [1:0] cnt, logic hit);
            if (!hit)
                return '0;
            return (cnt < FAULT_MAX) ? cnt + 2'd1 : FAULT_MAX;
        endfunction

        // Advance the detector by one accepted item and queue its result.
        function void note_sample(chamber_sample_t smp);
            detector_result_t res;
            logic [31:0] elapsed;
            int unsigned red_v, hist_v, pen;
            longint d_red, d_blue, d_pen;
            red_v = 32'(smp.red);
            elapsed = smp.secs - last_slow;
            if (elapsed >= SLOW_INTERVAL_S) begin
                for (int i = 0; i < HIST_DEPTH - 1; i++)
                    slow_hist[i] = slow_hist[i + 1];
                slow_hist[HIST_DEPTH - 1] = smp.red;
                last_slow = smp.secs;
            end

            red_base = move_base(red_base, red_v, red_thresh / FILTER_DIV);
            blue_base = move_base(blue_base, 32'(smp.blue), 32'(blue_thresh));

            leak_cnt = bump_fault(leak_cnt, smp.background > leak_thresh);
            chamber_cnt = bump_fault(chamber_cnt, red_base > {chamber_thresh, 16'h0});

            if (leak_cnt != FAULT_MAX && chamber_cnt != FAULT_MAX) begin
                d_red = trunc_q16(q16_gap(red_v, red_base));
                d_blue = trunc_q16(q16_gap(32'(smp.blue), blue_base));
                hist_v = 32'(slow_hist[HIST_DEPTH - 2]);
                pen = red_v;
                if (red_v > hist_v)
                    pen = red_v - ((red_v - hist_v) * PEN_NUM) / PEN_DEN;
                d_pen = trunc_q16(q16_gap(pen, red_base));

                // Smoke counter moves up or down once per item.
                if (d_pen > longint'(red_thresh)) begin
                    if (smoke_cnt < SMOKE_MAX)
                        smoke_cnt++;
                end else if (smoke_cnt > 0) begin
                    smoke_cnt--;
                end
                if (smoke_cnt >= SMOKE_MAX)
                    smoke_latch = 1'b1;

                // A flat blue channel leaves the particle counter alone.
                if (d_blue != 0) begin
                    if (d_red / d_blue > longint'(ratio)) begin
                        if (particle_cnt < PARTICLE_MAX)
                            particle_cnt++;
                    end else if (particle_cnt > 0) begin
                        particle_cnt--;
                    end
                    if (particle_cnt >= PARTICLE_MAX)
                        particle_latch = 1'b1;
                end else begin
                    flat_blue_items++;
                end
            end else begin
                fault_items++;
            end

            res.fill = '0;
            res.red_baseline = red_base[31:16];
            res.chamber_fault = (chamber_cnt == FAULT_MAX);
            res.leak_fault = (leak_cnt == FAULT_MAX);
            res.particle_alarm = particle_latch;
            res.smoke_alarm = smoke_latch;
            expected_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(detector_result_t got);
            detector_result_t want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with none pending, expected nothing, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("smoke_alarm", 16'(want.smoke_alarm), 16'(got.smoke_alarm));
            compare_field("big_particle_alarm", 16'(want.particle_alarm),
                          16'(got.particle_alarm));
            compare_field("light_leak_fault", 16'(want.leak_fault), 16'(got.leak_fault));
            compare_field("chamber_fault", 16'(want.chamber_fault),
                          16'(got.chamber_fault));
            compare_field("red_baseline", want.red_baseline, got.red_baseline);
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int          tx_idle_pct = 25;
    int          rx_idle_pct = 68;
    int          items_sent = 0;
    int          settings_used = 1;
    logic [31:0] clock_secs = '0;

    detector_scoreboard chamber_sb = new();

    smoke_chamber_detector_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Observe every handshake and apply random back-pressure on results.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            chamber_sb.note_sample(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            chamber_sb.check_result(m_tdata);
        if (aresetn && cfg_valid && cfg_ready)
            chamber_sb.set_register(cfg_index, cfg_data);
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Offer one item after a random idle stretch and hold it until taken.
    task automatic send_sample(input chamber_sample_t smp);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= smp;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_fields(input logic [15:0] red, input logic [15:0] blue,
                               input logic [15:0] bg, input logic [31:0] secs);
        chamber_sample_t smp;
        smp.red = red;
        smp.blue = blue;
        smp.background = bg;
        smp.secs = secs;
        clock_secs = secs;
        send_sample(smp);
    endtask

    // Stop offering items and wait until every result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (chamber_sb.pending() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write all registers while idle; 8-bit registers get junk in the upper byte.
    task automatic apply_settings(input logic [7:0] red_t, input logic [7:0] blue_t,
                                  input logic [15:0] leak_t, input logic [15:0] chamber_t,
                                  input logic [7:0] ratio_t);
        for (int k = FIRST_UNUSED_REG; k < 2 ** CFG_IDX_W; k++)
            cfg_write(k[CFG_IDX_W-1:0], 16'($urandom));
        cfg_write(REG_RED_THRESH, {8'($urandom), red_t});
        cfg_write(REG_BLUE_THRESH, {8'($urandom), blue_t});
        cfg_write(REG_LEAK_THRESH, leak_t);
        cfg_write(REG_CHAMBER_THRESH, chamber_t);
        cfg_write(REG_PART_RATIO, {8'($urandom), ratio_t});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [15:0] near_level(int center, int spread);
        int v;
        v = center - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // Mostly plausible chamber readings around the current baselines, some noise.
    function automatic chamber_sample_t random_sample();
        chamber_sample_t smp;
        int base_red, base_blue, pick;
        base_red = int'(chamber_sb.red_base[31:16]);
        base_blue = int'(chamber_sb.blue_base[31:16]);

        pick = $urandom_range(9);
        if (pick < 5)
            smp.red = near_level(base_red, 30);
        else if (pick < 7)
            smp.red = near_level(base_red + 2000, 2000);
        else
            smp.red = 16'($urandom);

        pick = $urandom_range(9);
        if (pick < 2)
            smp.blue = base_blue[15:0];
        else if (pick < 7)
            smp.blue = near_level(base_blue, 40);
        else
            smp.blue = 16'($urandom);

        if ($urandom_range(9) < 8)
            smp.background = 16'($urandom_range(0, chamber_sb.leak_thresh));
        else
            smp.background = 16'($urandom);

        if ($urandom_range(9) < 9)
            clock_secs = clock_secs + $urandom_range(0, 35);
        else
            clock_secs = $urandom;
        smp.secs = clock_secs;
        return smp;
    endfunction

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A zero sample leaves the baselines unloaded; the next one loads them.
        send_fields(16'd0, 16'd0, 16'd0, 32'd0);
        send_fields(16'd100, 16'd100, 16'd0, 32'd5);
        // Small rise moves the red baseline; blue sits on its baseline.
        send_fields(16'd103, 16'd100, 16'd0, 32'd10);
        // Rise, fall, then three rises in a row latch smoke and particle alarms.
        send_fields(16'd2000, 16'd150, 16'd0, 32'd40);
        send_fields(16'd90, 16'd150, 16'd0, 32'd45);
        send_fields(16'd3000, 16'd160, 16'd0, 32'd70);
        send_fields(16'd3000, 16'd160, 16'd0, 32'd75);
        send_fields(16'd3000, 16'd160, 16'd0, 32'd80);
        // Three leak hits in a row set the fault, a level at the threshold clears it.
        send_fields(16'd100, 16'd50, 16'd201, 32'd85);
        send_fields(16'd100, 16'd50, 16'hFFFF, 32'd90);
        send_fields(16'd100, 16'd50, 16'hFFFF, 32'd95);
        send_fields(16'd2000, 16'd50, 16'hFFFF, 32'd100);
        send_fields(16'd100, 16'd50, 16'd200, 32'd105);
        // Field extremes and timestamp wrap.
        send_fields(16'hFFFF, 16'hFFFF, 16'd0, 32'hFFFF_FFFF);
        send_fields(16'd0, 16'd0, 16'd0, 32'd0);
        send_fields(16'hFFFF, 16'd0, 16'd199, 32'd1000);
        // Backward time jump inserts into the history at once.
        send_fields(16'd50, 16'd40, 16'd0, 32'd500);
        send_fields(16'd0, 16'hFFFF, 16'd0, 32'd510);
        send_fields(16'd1, 16'd1, 16'd0, 32'd600);

        for (int p = 0; p < PHASES; p++) begin
            // Rotate between sender-heavy, receiver-heavy and no idling.
            case (p % 3)
                0: begin
                    tx_idle_pct = 25;
                    rx_idle_pct = 68;
                end
                1: begin
                    tx_idle_pct = 68;
                    rx_idle_pct = 25;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase

            if (p != 0) begin
                drain();
                case (p)
                    1: apply_settings(8'd0, 8'd0, 16'd0, 16'd0, 8'd0);
                    2: apply_settings(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF);
                    default: apply_settings(8'($urandom_range(0, 60)),
                                            8'($urandom_range(0, 255)),
                                            16'($urandom_range(50, 65535)),
                                            16'($urandom_range(0, 2000)),
                                            8'($urandom_range(0, 10)));
                endcase
            end

            while (items_sent < (p + 1) * ITEMS_PER_PHASE)
                send_sample(random_sample());
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d samples over %0d register settings, %0d with a fault set.",
                 items_sent, settings_used, chamber_sb.fault_items);
        $display("%0d samples had a flat blue channel; final alarms smoke %0b, particle %0b.",
                 chamber_sb.flat_blue_items, chamber_sb.smoke_latch,
                 chamber_sb.particle_latch);
        if (chamber_sb.errors == 0 && chamber_sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
